### sv/pkl_pkg.sv
// Shared types, constants and rounding helper for the planar arm kinematics core.
package pkl_pkg;

    localparam int LINK_COUNT = 4;
    localparam int LEN_W      = 16;
    localparam int RATE_W     = 16;
    localparam int WRATE_W    = 18;
    localparam int TRIG_W     = 18;
    localparam int PROD_W     = 34;
    localparam int DPROD_W    = 52;
    localparam int ACC_W      = 56;
    localparam int OUT_W      = 24;
    localparam int COL_W      = 2;
    localparam int IDX_W      = 2;

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd4096;

    localparam int POS_SHIFT  = 16;
    localparam int JDOT_SHIFT = 28;

    localparam logic signed [ACC_W-1:0] ACC_OUT_MAX = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] ACC_OUT_MIN = -ACC_W'(8388608);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [WRATE_W-1:0] wrate_t;
    typedef logic signed [OUT_W-1:0]   out_t;

    typedef struct packed {
        out_t jac_x;
        out_t jac_y;
        out_t jdot_x;
        out_t jdot_y;
    } col_res_t;

    // Round half up at the given shift, then clamp to the 24 bit output range.
    function automatic out_t rnd_sat(input logic signed [ACC_W-1:0] v, input int sh);
        logic signed [ACC_W-1:0] r;
        r = (v + (ACC_W'(1) <<< (sh - 1))) >>> sh;
        if (r > ACC_OUT_MAX)
            rnd_sat = 24'sh7FFFFF;
        else if (r < ACC_OUT_MIN)
            rnd_sat = 24'sh800000;
        else
            rnd_sat = r[OUT_W-1:0];
    endfunction

endpackage

### sv/pkl_sincos.sv
// Pipelined sine and cosine lanes, one per link, polynomial quarter-wave evaluation.
module pkl_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [ANGLE_BITS-1:0]  phase [pkl_pkg::LINK_COUNT],
    output logic                   out_valid,
    output pkl_pkg::trig_t         sin_q [pkl_pkg::LINK_COUNT],
    output pkl_pkg::trig_t         cos_q [pkl_pkg::LINK_COUNT]
);
    import pkl_pkg::*;

    localparam int ZSH = ANGLE_BITS - 10;

    logic [4:0] v_reg;

    logic [16:0] za1_reg [LINK_COUNT], zb1_reg [LINK_COUNT];
    logic [16:0] a2_1_reg [LINK_COUNT], b2_1_reg [LINK_COUNT];
    logic [1:0]  q1_reg [LINK_COUNT];

    logic [16:0] za2_reg [LINK_COUNT], zb2_reg [LINK_COUNT];
    logic [16:0] a2_2_reg [LINK_COUNT], b2_2_reg [LINK_COUNT];
    logic [15:0] ta2_reg [LINK_COUNT], tb2_reg [LINK_COUNT];
    logic [1:0]  q2_reg [LINK_COUNT];

    logic [16:0] za3_reg [LINK_COUNT], zb3_reg [LINK_COUNT];
    logic [16:0] ua3_reg [LINK_COUNT], ub3_reg [LINK_COUNT];
    logic [1:0]  q3_reg [LINK_COUNT];

    logic [16:0] ra4_reg [LINK_COUNT], rb4_reg [LINK_COUNT];
    logic [1:0]  q4_reg [LINK_COUNT];

    trig_t sin_reg [LINK_COUNT], cos_reg [LINK_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LINK_COUNT; k++)
        begin
            logic [ANGLE_BITS+5:0] zx;
            logic [16:0] za, zb;
            logic [33:0] pa, pb;
            logic [29:0] ca, cb;
            logic [32:0] da, db;
            logic [33:0] ea, eb;
            zx = {phase[k][ANGLE_BITS-3:0], 8'b0};
            za = {1'b0, zx[ZSH +: 16]};
            zb = 17'h10000 - za;
            pa = za * za;
            pb = zb * zb;
            // stage 1: z squared
            za1_reg[k]  <= za;
            zb1_reg[k]  <= zb;
            a2_1_reg[k] <= pa[32:16];
            b2_1_reg[k] <= pb[32:16];
            q1_reg[k]   <= phase[k][ANGLE_BITS-1 -: 2];
            // stage 2: inner term
            ca = SIN_C * a2_1_reg[k];
            cb = SIN_C * b2_1_reg[k];
            ta2_reg[k]  <= SIN_B - {2'b0, ca[29:16]};
            tb2_reg[k]  <= SIN_B - {2'b0, cb[29:16]};
            za2_reg[k]  <= za1_reg[k];
            zb2_reg[k]  <= zb1_reg[k];
            a2_2_reg[k] <= a2_1_reg[k];
            b2_2_reg[k] <= b2_1_reg[k];
            q2_reg[k]   <= q1_reg[k];
            // stage 3: outer term
            da = ta2_reg[k] * a2_2_reg[k];
            db = tb2_reg[k] * b2_2_reg[k];
            ua3_reg[k]  <= SIN_A - da[32:16];
            ub3_reg[k]  <= SIN_A - db[32:16];
            za3_reg[k]  <= za2_reg[k];
            zb3_reg[k]  <= zb2_reg[k];
            q3_reg[k]   <= q2_reg[k];
            // stage 4: final scale by z
            ea = ua3_reg[k] * za3_reg[k];
            eb = ub3_reg[k] * zb3_reg[k];
            ra4_reg[k]  <= ea[32:16];
            rb4_reg[k]  <= eb[32:16];
            q4_reg[k]   <= q3_reg[k];
            // stage 5: quadrant mapping
            case (q4_reg[k])
                QUAD_0:
                begin
                    sin_reg[k] <= trig_t'(ra4_reg[k]);
                    cos_reg[k] <= trig_t'(rb4_reg[k]);
                end
                QUAD_1:
                begin
                    sin_reg[k] <= trig_t'(rb4_reg[k]);
                    cos_reg[k] <= -trig_t'(ra4_reg[k]);
                end
                QUAD_2:
                begin
                    sin_reg[k] <= -trig_t'(ra4_reg[k]);
                    cos_reg[k] <= -trig_t'(rb4_reg[k]);
                end
                default:
                begin
                    sin_reg[k] <= -trig_t'(rb4_reg[k]);
                    cos_reg[k] <= trig_t'(ra4_reg[k]);
                end
            endcase
        end
    end

    assign out_valid = v_reg[4];
    assign sin_q     = sin_reg;
    assign cos_q     = cos_reg;

endmodule

### sv/pkl_sum.sv
// Link products, column suffix sums, rounding and saturation pipeline.
module pkl_sum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [pkl_pkg::LEN_W-1:0]      len [pkl_pkg::LINK_COUNT],
    input  pkl_pkg::trig_t                 sin_q [pkl_pkg::LINK_COUNT],
    input  pkl_pkg::trig_t                 cos_q [pkl_pkg::LINK_COUNT],
    input  pkl_pkg::wrate_t                wrate [pkl_pkg::LINK_COUNT],
    input  logic [pkl_pkg::IDX_W-1:0]      end_link,
    output logic                           out_valid,
    output pkl_pkg::out_t                  pos_x,
    output pkl_pkg::out_t                  pos_y,
    output pkl_pkg::col_res_t              res [pkl_pkg::LINK_COUNT]
);
    import pkl_pkg::*;

    logic [3:0] v_reg;

    logic signed [PROD_W-1:0]  lc1_reg [LINK_COUNT], ls1_reg [LINK_COUNT];
    wrate_t                    w1_reg [LINK_COUNT];

    logic signed [PROD_W-1:0]  lc2_reg [LINK_COUNT], ls2_reg [LINK_COUNT];
    logic signed [DPROD_W-1:0] dc2_reg [LINK_COUNT], ds2_reg [LINK_COUNT];

    logic signed [ACC_W-1:0]   px3_reg, py3_reg;
    logic signed [ACC_W-1:0]   jx3_reg [LINK_COUNT], jy3_reg [LINK_COUNT];
    logic signed [ACC_W-1:0]   dx3_reg [LINK_COUNT], dy3_reg [LINK_COUNT];

    out_t     px4_reg, py4_reg;
    col_res_t res4_reg [LINK_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [ACC_W-1:0] sx, sy, ax, ay;
        logic signed [PROD_W:0]  pc, ps;
        // stage 1: length times trig, links past the end dropped
        for (int k = 0; k < LINK_COUNT; k++)
        begin
            pc = $signed({1'b0, len[k]}) * cos_q[k];
            ps = $signed({1'b0, len[k]}) * sin_q[k];
            if (IDX_W'(k) > end_link)
            begin
                lc1_reg[k] <= '0;
                ls1_reg[k] <= '0;
            end
            else
            begin
                lc1_reg[k] <= pc[PROD_W-1:0];
                ls1_reg[k] <= ps[PROD_W-1:0];
            end
            w1_reg[k] <= wrate[k];
        end
        // stage 2: rate weighting
        for (int k = 0; k < LINK_COUNT; k++)
        begin
            dc2_reg[k] <= w1_reg[k] * lc1_reg[k];
            ds2_reg[k] <= w1_reg[k] * ls1_reg[k];
            lc2_reg[k] <= lc1_reg[k];
            ls2_reg[k] <= ls1_reg[k];
        end
        // stage 3: suffix sums per column
        for (int c = 0; c < LINK_COUNT; c++)
        begin
            sx = '0;
            sy = '0;
            ax = '0;
            ay = '0;
            for (int k = c; k < LINK_COUNT; k++)
            begin
                sx = sx + ACC_W'(lc2_reg[k]);
                sy = sy + ACC_W'(ls2_reg[k]);
                ax = ax + ACC_W'(dc2_reg[k]);
                ay = ay + ACC_W'(ds2_reg[k]);
            end
            jx3_reg[c] <= -sy;
            jy3_reg[c] <= sx;
            dx3_reg[c] <= -ax;
            dy3_reg[c] <= -ay;
            if (c == 0)
            begin
                px3_reg <= sx;
                py3_reg <= sy;
            end
        end
        // stage 4: round positions and Jacobian to Q12, round the rate terms at JDOT_SHIFT, and clamp
        px4_reg <= rnd_sat(px3_reg, POS_SHIFT);
        py4_reg <= rnd_sat(py3_reg, POS_SHIFT);
        for (int c = 0; c < LINK_COUNT; c++)
        begin
            res4_reg[c].jac_x  <= rnd_sat(jx3_reg[c], POS_SHIFT);
            res4_reg[c].jac_y  <= rnd_sat(jy3_reg[c], POS_SHIFT);
            res4_reg[c].jdot_x <= rnd_sat(dx3_reg[c], JDOT_SHIFT);
            res4_reg[c].jdot_y <= rnd_sat(dy3_reg[c], JDOT_SHIFT);
        end
    end

    assign out_valid = v_reg[3];
    assign pos_x     = px4_reg;
    assign pos_y     = py4_reg;
    assign res       = res4_reg;

endmodule

### sv/planar_arm_kinematics_core.sv
// Top level: config registers, joint accumulation, pipeline and column emitter.
//
// Usage: present four joint angles, four joint rates and end_link with start
// high; the transaction is taken at an edge where busy is low. busy rises
// after each accepted transaction and holds off the next one, since the
// single result port emits four columns per input.
// Results come out on consecutive cycles, columns 0 to 3, each marked
// by result_valid for one cycle; last flags column 3 and pos_x/pos_y repeat
// on every column. Column 0 follows the accepting edge through joint
// accumulation, sine/cosine evaluation, products, sums and rounding, and
// the column buffer.
// Link lengths are written through wr_en/wr_index/wr_data by the user only while idle; the block does not enforce it.
// Reset loads every link length with 1.0 and empties the pipeline.
// The receiver cannot stall: every result is shown for exactly one cycle.
module planar_arm_kinematics_core #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [pkl_pkg::IDX_W-1:0]     wr_index,
    input  logic [pkl_pkg::LEN_W-1:0]     wr_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [ANGLE_BITS-1:0]         angle_j0,
    input  logic [ANGLE_BITS-1:0]         angle_j1,
    input  logic [ANGLE_BITS-1:0]         angle_j2,
    input  logic [ANGLE_BITS-1:0]         angle_j3,
    input  logic signed [pkl_pkg::RATE_W-1:0] rate_j0,
    input  logic signed [pkl_pkg::RATE_W-1:0] rate_j1,
    input  logic signed [pkl_pkg::RATE_W-1:0] rate_j2,
    input  logic signed [pkl_pkg::RATE_W-1:0] rate_j3,
    input  logic [pkl_pkg::IDX_W-1:0]     end_link,
    output logic                          result_valid,
    output logic [pkl_pkg::COL_W-1:0]     column,
    output pkl_pkg::out_t                 pos_x,
    output pkl_pkg::out_t                 pos_y,
    output pkl_pkg::out_t                 jac_x,
    output pkl_pkg::out_t                 jac_y,
    output pkl_pkg::out_t                 jdot_x,
    output pkl_pkg::out_t                 jdot_y,
    output logic                          last
);
    import pkl_pkg::*;

    localparam int SC_LAT = 5;

    logic [LEN_W-1:0] len_reg [LINK_COUNT];
    logic [1:0]       hold_reg;
    logic             accept;

    logic [ANGLE_BITS-1:0] ang_in [LINK_COUNT];
    logic signed [RATE_W-1:0] rate_in [LINK_COUNT];
    logic [ANGLE_BITS-1:0] ph_next [LINK_COUNT];
    wrate_t                w_next [LINK_COUNT];

    logic                  v0_reg;
    logic [ANGLE_BITS-1:0] ph_reg [LINK_COUNT];
    wrate_t                w_reg [LINK_COUNT];
    logic [IDX_W-1:0]      end_reg;

    wrate_t           wd_reg [SC_LAT][LINK_COUNT];
    logic [IDX_W-1:0] ed_reg [SC_LAT];

    logic  sc_valid;
    trig_t sin_q [LINK_COUNT], cos_q [LINK_COUNT];

    logic     sum_valid;
    out_t     sum_px, sum_py;
    col_res_t sum_res [LINK_COUNT];

    logic             act_reg;
    logic [COL_W-1:0] col_reg;
    out_t             px_reg, py_reg;
    col_res_t         buf_reg [LINK_COUNT];

    assign accept = start && !busy;
    assign busy   = (hold_reg != 2'd0);

    assign ang_in  = '{angle_j0, angle_j1, angle_j2, angle_j3};
    assign rate_in = '{rate_j0, rate_j1, rate_j2, rate_j3};

    // cumulative angles wrap modulo one turn, cumulative rates grow to 18 bits
    always_comb
    begin
        ph_next[0] = ang_in[0];
        w_next[0]  = WRATE_W'(rate_in[0]);
        for (int k = 1; k < LINK_COUNT; k++)
        begin
            ph_next[k] = ph_next[k-1] + ang_in[k];
            w_next[k]  = w_next[k-1] + WRATE_W'(rate_in[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LINK_COUNT; k++)
            begin
                len_reg[k] <= LEN_RESET;
            end
            hold_reg <= '0;
            v0_reg   <= 1'b0;
            act_reg  <= 1'b0;
            col_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                len_reg[wr_index] <= wr_data;
            end
            if (accept)
                hold_reg <= 2'd3;
            else if (hold_reg != 2'd0)
                hold_reg <= hold_reg - 2'd1;
            v0_reg <= accept;
            // advance through the four columns, restart on a fresh result set
            if (sum_valid)
            begin
                act_reg <= 1'b1;
                col_reg <= '0;
            end
            else if (act_reg)
            begin
                col_reg <= col_reg + COL_W'(1);
                if (col_reg == COL_W'(LINK_COUNT - 1))
                    act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ph_reg  <= ph_next;
            w_reg   <= w_next;
            end_reg <= end_link;
        end
        // delay the rates and end index alongside the sine/cosine pipeline
        wd_reg[0] <= w_reg;
        ed_reg[0] <= end_reg;
        for (int s = 1; s < SC_LAT; s++)
        begin
            wd_reg[s] <= wd_reg[s-1];
            ed_reg[s] <= ed_reg[s-1];
        end
        if (sum_valid)
        begin
            px_reg  <= sum_px;
            py_reg  <= sum_py;
            buf_reg <= sum_res;
        end
    end

    pkl_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .phase     (ph_reg),
        .out_valid (sc_valid),
        .sin_q     (sin_q),
        .cos_q     (cos_q)
    );

    pkl_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_valid),
        .len       (len_reg),
        .sin_q     (sin_q),
        .cos_q     (cos_q),
        .wrate     (wd_reg[SC_LAT-1]),
        .end_link  (ed_reg[SC_LAT-1]),
        .out_valid (sum_valid),
        .pos_x     (sum_px),
        .pos_y     (sum_py),
        .res       (sum_res)
    );

    assign result_valid = act_reg;
    assign column       = col_reg;
    assign last         = (col_reg == COL_W'(LINK_COUNT - 1));
    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign jac_x        = buf_reg[col_reg].jac_x;
    assign jac_y        = buf_reg[col_reg].jac_y;
    assign jdot_x       = buf_reg[col_reg].jdot_x;
    assign jdot_y       = buf_reg[col_reg].jdot_y;

endmodule

### test/testbench.sv
// Self-checking testbench for the planar arm kinematics core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pkl_pkg::*;

    localparam int NLINK     = 4;
    localparam int WD_LIMIT  = 2000;
    localparam int DRAIN_CYC = 30;

    typedef enum logic [1:0] {REG_LEN1 = 2'd0, REG_LEN2 = 2'd1, REG_LEN3 = 2'd2,
                              REG_LEN4 = 2'd3} reg_idx_e;

    typedef struct packed {
        logic [1:0]  column;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] jac_x;
        logic [23:0] jac_y;
        logic [23:0] jdot_x;
        logic [23:0] jdot_y;
        logic        last;
    } column_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [1:0] wr_index = '0;
    logic [15:0] wr_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [15:0] angle_j0 = '0, angle_j1 = '0, angle_j2 = '0, angle_j3 = '0;
    logic signed [15:0] rate_j0 = '0, rate_j1 = '0, rate_j2 = '0, rate_j3 = '0;
    logic [1:0] end_link = '0;
    logic result_valid;
    logic [1:0] column;
    out_t pos_x, pos_y, jac_x, jac_y, jdot_x, jdot_y;
    logic last;

    planar_arm_kinematics_core dut (.*);

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [15:0] arm_len [NLINK];
    column_res_t expected_cols [$];
    int errors = 0;
    int n_items = 0;
    int n_cols = 0;
    int idle_pct = 0;
    int idle_cnt = 0;
    logic timed_out = 1'b0;

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        errors++;
        $display("MISMATCH col %0d %s: got %h want %h", n_cols, what, got, want);
    endtask

    function automatic longint quarter_sine(input longint z);
        longint z2, t, u;
        z2 = (z * z) >>> 16;
        t = 42048 - ((4640 * z2) >>> 16);
        u = 102944 - ((t * z2) >>> 16);
        return (u * z) >>> 16;
    endfunction

    function automatic logic [23:0] round_sat(input longint v, input int sh);
        longint r;
        r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    // Compute the four column results of one transaction.
    task automatic predict_columns(input logic [15:0] ang [NLINK],
                                   input logic signed [15:0] rt [NLINK],
                                   input logic [1:0] e);
        longint lc [NLINK], ls [NLINK], w [NLINK];
        logic [15:0] ph;
        longint acc, a, b, s, co, z, px, py, jx, jy, dx, dy;
        column_res_t r;
        ph = '0;
        acc = 0;
        px = 0;
        py = 0;
        for (int k = 0; k < NLINK; k++) begin
            ph = ph + ang[k];
            acc += longint'(rt[k]);
            w[k] = acc;
            z = longint'(ph[13:0]) << 2;
            a = quarter_sine(z);
            b = quarter_sine(65536 - z);
            case (ph[15:14])
                QUAD_0: begin s = a; co = b; end
                QUAD_1: begin s = b; co = -a; end
                QUAD_2: begin s = -a; co = -b; end
                default: begin s = -b; co = a; end
            endcase
            lc[k] = longint'(arm_len[k]) * co;
            ls[k] = longint'(arm_len[k]) * s;
            if (k <= e) begin
                px += lc[k];
                py += ls[k];
            end
        end
        for (int c = 0; c < NLINK; c++) begin
            jx = 0; jy = 0; dx = 0; dy = 0;
            for (int k = c; k <= e; k++) begin
                jx -= ls[k];
                jy += lc[k];
                dx -= w[k] * lc[k];
                dy -= w[k] * ls[k];
            end
            r.column = c[1:0];
            r.pos_x = round_sat(px, 16);
            r.pos_y = round_sat(py, 16);
            r.jac_x = round_sat(jx, 16);
            r.jac_y = round_sat(jy, 16);
            r.jdot_x = round_sat(dx, 28);
            r.jdot_y = round_sat(dy, 28);
            r.last = (c == NLINK - 1);
            expected_cols.push_back(r);
        end
    endtask

    // Check each column result against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && result_valid) begin
            column_res_t want;
            if (expected_cols.size() == 0) begin
                errors++;
                $display("MISMATCH unexpected result, column %0d", column);
            end else begin
                want = expected_cols.pop_front();
                if (column !== want.column)
                    report_mismatch("column", 24'(column), 24'(want.column));
                if (pos_x !== want.pos_x) report_mismatch("pos_x", pos_x, want.pos_x);
                if (pos_y !== want.pos_y) report_mismatch("pos_y", pos_y, want.pos_y);
                if (jac_x !== want.jac_x) report_mismatch("jac_x", jac_x, want.jac_x);
                if (jac_y !== want.jac_y) report_mismatch("jac_y", jac_y, want.jac_y);
                if (jdot_x !== want.jdot_x) report_mismatch("jdot_x", jdot_x, want.jdot_x);
                if (jdot_y !== want.jdot_y) report_mismatch("jdot_y", jdot_y, want.jdot_y);
                if (last !== want.last) report_mismatch("last", 24'(last), 24'(want.last));
            end
            n_cols++;
        end
    end

    // Watchdog: count cycles with no accepted transaction or result.
    always @(posedge clk) begin
        if ((start && !busy) || result_valid)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("watchdog expired");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Leave start high on return; the next caller drops or reloads it.
    task automatic send_item(input logic [15:0] ang [NLINK],
                             input logic signed [15:0] rt [NLINK],
                             input logic [1:0] e);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        angle_j0 <= ang[0]; angle_j1 <= ang[1]; angle_j2 <= ang[2]; angle_j3 <= ang[3];
        rate_j0 <= rt[0]; rate_j1 <= rt[1]; rate_j2 <= rt[2]; rate_j3 <= rt[3];
        end_link <= e;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_columns(ang, rt, e);
        n_items++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_cols.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Leave wr_en high on return; the caller drops it after the last write.
    task automatic write_len(input reg_idx_e idx, input logic [15:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        arm_len[idx] = val;
    endtask

    task automatic send_random(input int count);
        logic [15:0] ang [NLINK];
        logic signed [15:0] rt [NLINK];
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < NLINK; k++) begin
                ang[k] = 16'($urandom);
                case ($urandom_range(3, 0))
                    0: rt[k] = $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
                    1: rt[k] = 16'($urandom_range(255, 0) - 128);
                    default: rt[k] = 16'($urandom);
                endcase
            end
            send_item(ang, rt, 2'($urandom_range(3, 0)));
        end
    endtask

    task automatic test_directed();
        logic [15:0] ang [NLINK];
        logic signed [15:0] rt [NLINK];
        logic [15:0] corners [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                     16'hFFFF, 16'h3FFF};
        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < NLINK; k++) begin
                ang[k] = corners[(i + k) % 6];
                rt[k] = (i % 2) ? 16'sh7FFF : 16'sh8000;
            end
            send_item(ang, rt, i[1:0]);
        end
        for (int e = 0; e < 4; e++) begin
            for (int k = 0; k < NLINK; k++) begin
                ang[k] = 16'h0000;
                rt[k] = 16'sh0000;
            end
            send_item(ang, rt, e[1:0]);
        end
    endtask

    task automatic test_max_lengths();
        wait_drained();
        write_len(REG_LEN1, 16'hFFFF);
        write_len(REG_LEN2, 16'hFFFF);
        write_len(REG_LEN3, 16'hFFFF);
        write_len(REG_LEN4, 16'hFFFF);
        wr_en <= 1'b0;
        send_random(15);
    endtask

    task automatic test_zero_and_mixed_lengths();
        wait_drained();
        write_len(REG_LEN1, 16'h0000);
        write_len(REG_LEN2, 16'h0000);
        write_len(REG_LEN3, 16'h0000);
        write_len(REG_LEN4, 16'h0000);
        wr_en <= 1'b0;
        send_random(5);
        wait_drained();
        write_len(REG_LEN1, 16'($urandom));
        write_len(REG_LEN2, 16'($urandom));
        write_len(REG_LEN3, 16'($urandom));
        write_len(REG_LEN4, 16'($urandom));
        wr_en <= 1'b0;
        send_random(20);
    endtask

    task automatic test_idle_phases();
        int pct [4] = '{0, 87, 0, 20};
        for (int p = 0; p < 4; p++) begin
            idle_pct = pct[p];
            send_random(20);
        end
        idle_pct = 0;
    endtask

    initial begin
        for (int k = 0; k < NLINK; k++) arm_len[k] = 16'd4096;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idle_phases();
        test_max_lengths();
        test_zero_and_mixed_lengths();
        wait_drained();
        $display("covered %0d transactions, %0d column results, idle phases and",
                 n_items, n_cols);
        $display("link lengths from zero to full scale");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
